FILE: rtl/srb_pkg.sv
// srb_pkg: constants, codes and control types of the scan ring buffer
// no dependencies; used by the interfaces and every module of the block
package srb_pkg;

    localparam int SCANS              = 8;
    localparam int MAX_READINGS       = 2048;
    localparam int READING_BITS       = 16;
    localparam int HALF_TURN_CENTIDEG = 18000;

    localparam int FUNC_W    = 2;
    localparam int ANGLE_W   = 15;
    localparam int STATUS_W  = 2;
    localparam int RES_W     = 7;
    localparam int RES_MIN   = 10;
    localparam int RES_MAX   = 100;
    localparam int RES_RESET = 100;

    localparam int SLOT_W      = (SCANS > 1) ? $clog2(SCANS) : 1;
    localparam int COUNT_W     = $clog2(SCANS + 1);
    localparam int POS_W       = $clog2(MAX_READINGS);
    localparam int LEN_W       = $clog2(MAX_READINGS + 1);
    localparam int ADDR_W      = SLOT_W + POS_W;
    localparam int STORE_DEPTH = SCANS * (2 ** POS_W);

    localparam int DIV_W     = ANGLE_W;
    localparam int DIV_STEPS = DIV_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam int RECLEN_RAW   = HALF_TURN_CENTIDEG / RES_RESET + 1;
    localparam int RECLEN_RESET = (RECLEN_RAW > MAX_READINGS) ? MAX_READINGS : RECLEN_RAW;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_QUERY = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic div_start;
        logic div_len;
        logic len_load;
        logic lookup;
        logic out_load;
    } srb_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        func_t func;
        logic  empty;
        logic  div_busy;
        logic  len_stale;
        logic  cfg_write;
        logic  out_free;
    } srb_stat_t;

endpackage

FILE: rtl/srb_if.sv
// srb_in_if and srb_out_if: valid/ready channels of the scan ring buffer
// depends on srb_pkg
interface srb_in_if;
    import srb_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [FUNC_W-1:0]       func;
    logic [READING_BITS-1:0] reading;
    logic                    last_reading;
    logic [ANGLE_W-1:0]      angle_centideg;

    modport source (output valid, func, reading, last_reading, angle_centideg, input ready);
    modport sink   (input valid, func, reading, last_reading, angle_centideg, output ready);
endinterface

interface srb_out_if;
    import srb_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [READING_BITS-1:0] distance;
    logic                    last_of_scan;
    logic [STATUS_W-1:0]     status;

    modport source (output valid, distance, last_of_scan, status, input ready);
    modport sink   (input valid, distance, last_of_scan, status, output ready);
endinterface

FILE: rtl/srb_div.sv
// srb_div: restoring divider, one quotient bit per cycle
// depends on srb_pkg
module srb_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [srb_pkg::DIV_W-1:0]  dividend,
    input  logic [srb_pkg::RES_W-1:0]  divisor,
    output logic                       busy,
    output logic [srb_pkg::DIV_W-1:0]  quotient
);
    import srb_pkg::*;

    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [RES_W-1:0]  rem_reg, rem_next;
    logic [RES_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic [RES_W:0]    shifted;
    logic [RES_W:0]    diff;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = STEP_W'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the low bits hold it
            rem_next  = fits ? diff[RES_W-1:0] : shifted[RES_W-1:0];
            quo_next  = {quo_reg[DIV_W-2:0], fits};
            step_next = step_reg - 1'b1;
            busy_next = (step_reg != STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/srb_ctrl.sv
// srb_ctrl: sequencing state machine of the scan ring buffer
// depends on srb_pkg; drives srb_dp through srb_cmd_t
module srb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  srb_pkg::srb_stat_t stat,
    output srb_pkg::srb_cmd_t  cmd
);
    import srb_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_EXEC    = 6'b000010,
        ST_DIV     = 6'b000100,
        ST_LOOKUP  = 6'b001000,
        ST_RESP    = 6'b010000,
        ST_LENCALC = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = !stat.len_stale && !stat.cfg_write;
                if (stat.len_stale && !stat.cfg_write)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_len   = 1'b1;
                    state_next    = ST_LENCALC;
                end
                else if (in_valid && in_ready)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.func == FUNC_QUERY && !stat.empty)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_LENCALC:
            begin
                // a fresh write restarts the computation from idle
                if (stat.cfg_write)
                begin
                    state_next = ST_IDLE;
                end
                else if (!stat.div_busy)
                begin
                    cmd.len_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/srb_dp.sv
// srb_dp: scan store, ring pointers, length register and output register
// depends on srb_pkg and srb_div; commanded by srb_ctrl
module srb_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  srb_pkg::srb_cmd_t                cmd,
    output srb_pkg::srb_stat_t               stat,
    input  logic                             cfg_we,
    input  logic [srb_pkg::RES_W-1:0]        cfg_wdata,
    input  logic [srb_pkg::FUNC_W-1:0]       in_func,
    input  logic [srb_pkg::READING_BITS-1:0] in_reading,
    input  logic                             in_last,
    input  logic [srb_pkg::ANGLE_W-1:0]      in_angle,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [srb_pkg::READING_BITS-1:0] out_distance,
    output logic                             out_last,
    output logic [srb_pkg::STATUS_W-1:0]     out_status
);
    import srb_pkg::*;

    // configuration and derived record length
    logic [RES_W-1:0] res_reg, res_next;
    logic [RES_W-1:0] eff_res;
    logic [LEN_W-1:0] reclen_reg, reclen_next;
    logic             stale_reg, stale_next;

    // captured item
    func_t                   func_reg;
    logic [READING_BITS-1:0] reading_reg;
    logic                    last_reg;
    logic [ANGLE_W-1:0]      angle_reg;

    // ring state
    logic [SLOT_W-1:0]  oldest_reg, oldest_next;
    logic [SLOT_W-1:0]  fill_reg, fill_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0]   wpos_reg, wpos_next;
    logic [LEN_W-1:0]   rpos_reg, rpos_next;
    logic [LEN_W-1:0]   scan_len_mem [SCANS];

    // result held for the output register
    logic    hit_reg, hit_next;
    logic    rlast_reg, rlast_next;
    status_t rstat_reg, rstat_next;

    // store
    logic [READING_BITS-1:0] store_mem [STORE_DEPTH];
    logic [READING_BITS-1:0] mem_q_reg;
    logic                    mem_we, mem_re;
    logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
    logic                    len_we;
    logic [LEN_W-1:0]        len_wdata;
    logic [LEN_W-1:0]        len_rd;
    logic [SLOT_W-1:0]       len_ridx;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [READING_BITS-1:0] out_dist_reg;
    logic                    out_last_reg;
    status_t                 out_stat_reg;

    logic              drop;
    logic [SLOT_W-1:0] newest;
    logic [DIV_W-1:0]  dividend;
    logic              div_busy;
    logic [DIV_W-1:0]  quo;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(SCANS - 1)) ? '0 : s + 1'b1;
    endfunction

    always_comb
    begin
        if (res_reg < RES_W'(RES_MIN))
            eff_res = RES_W'(RES_MIN);
        else if (res_reg > RES_W'(RES_MAX))
            eff_res = RES_W'(RES_MAX);
        else
            eff_res = res_reg;
    end

    assign dividend = cmd.div_len ? DIV_W'(HALF_TURN_CENTIDEG) : angle_reg;

    srb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (eff_res),
        .busy     (div_busy),
        .quotient (quo)
    );

    assign drop     = (wpos_reg == '0) && (count_reg >= COUNT_W'(SCANS));
    assign newest   = (fill_reg == '0) ? SLOT_W'(SCANS - 1) : fill_reg - 1'b1;
    assign len_ridx = cmd.lookup ? newest : oldest_reg;
    assign len_rd   = scan_len_mem[len_ridx];

    always_comb
    begin
        res_next    = cfg_we ? cfg_wdata : res_reg;
        stale_next  = cfg_we ? 1'b1 : (cmd.len_load ? 1'b0 : stale_reg);
        reclen_next = reclen_reg;
        if (cmd.len_load)
        begin
            reclen_next = (quo >= DIV_W'(MAX_READINGS)) ? LEN_W'(MAX_READINGS)
                                                        : LEN_W'(quo) + 1'b1;
        end

        oldest_next = oldest_reg;
        fill_next   = fill_reg;
        count_next  = count_reg;
        wpos_next   = wpos_reg;
        rpos_next   = rpos_reg;
        hit_next    = hit_reg;
        rlast_next  = rlast_reg;
        rstat_next  = rstat_reg;
        mem_we      = 1'b0;
        mem_waddr   = {fill_reg, wpos_reg[POS_W-1:0]};
        mem_re      = 1'b0;
        mem_raddr   = {oldest_reg, rpos_reg[POS_W-1:0]};
        len_we      = 1'b0;
        len_wdata   = wpos_reg;

        if (cmd.exec)
        begin
            hit_next   = 1'b0;
            rlast_next = 1'b0;
            rstat_next = STATUS_OK;
            unique case (func_reg)
                FUNC_WRITE:
                begin
                    // full ring: first reading of a new scan frees the oldest
                    if (drop)
                    begin
                        oldest_next = next_slot(oldest_reg);
                        count_next  = count_reg - 1'b1;
                        rpos_next   = '0;
                    end
                    if (wpos_reg < reclen_reg)
                    begin
                        mem_we    = 1'b1;
                        wpos_next = wpos_reg + 1'b1;
                    end
                    if (last_reg)
                    begin
                        // stored length counts this word when it was kept
                        len_we     = 1'b1;
                        len_wdata  = wpos_next;
                        fill_next  = next_slot(fill_reg);
                        count_next = count_next + 1'b1;
                        wpos_next  = '0;
                    end
                end
                FUNC_READ:
                begin
                    if (count_reg == '0)
                    begin
                        rstat_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        mem_re   = 1'b1;
                        hit_next = rpos_reg < len_rd;
                        if ({1'b0, rpos_reg} + 1'b1 >= {1'b0, reclen_reg})
                        begin
                            rlast_next  = 1'b1;
                            oldest_next = next_slot(oldest_reg);
                            count_next  = count_reg - 1'b1;
                            rpos_next   = '0;
                        end
                        else
                        begin
                            rpos_next = rpos_reg + 1'b1;
                        end
                    end
                end
                FUNC_CLEAR:
                begin
                    oldest_next = '0;
                    fill_next   = '0;
                    count_next  = '0;
                    wpos_next   = '0;
                    rpos_next   = '0;
                end
                FUNC_QUERY:
                begin
                    if (count_reg == '0)
                    begin
                        rstat_next = STATUS_EMPTY;
                    end
                end
                default:
                begin
                    rstat_next = STATUS_OK;
                end
            endcase
        end

        if (cmd.lookup)
        begin
            mem_raddr = {newest, quo[POS_W-1:0]};
            if (quo >= DIV_W'(reclen_reg))
            begin
                rstat_next = STATUS_RANGE;
                hit_next   = 1'b0;
            end
            else
            begin
                mem_re     = 1'b1;
                rstat_next = STATUS_OK;
                hit_next   = quo < DIV_W'(len_rd);
            end
        end

        out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg       <= RES_W'(RES_RESET);
            reclen_reg    <= LEN_W'(RECLEN_RESET);
            stale_reg     <= 1'b0;
            oldest_reg    <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            wpos_reg      <= '0;
            rpos_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            res_reg       <= res_next;
            reclen_reg    <= reclen_next;
            stale_reg     <= stale_next;
            oldest_reg    <= oldest_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            wpos_reg      <= wpos_next;
            rpos_reg      <= rpos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg    <= func_t'(in_func);
            reading_reg <= in_reading;
            last_reg    <= in_last;
            angle_reg   <= in_angle;
        end
        hit_reg   <= hit_next;
        rlast_reg <= rlast_next;
        rstat_reg <= rstat_next;
        if (cmd.out_load)
        begin
            out_dist_reg <= hit_reg ? mem_q_reg : '0;
            out_last_reg <= rlast_reg;
            out_stat_reg <= rstat_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= reading_reg;
        end
        if (mem_re)
        begin
            mem_q_reg <= store_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            scan_len_mem[fill_reg] <= len_wdata;
        end
    end

    assign stat.func      = func_reg;
    assign stat.empty     = (count_reg == '0);
    assign stat.div_busy  = div_busy;
    assign stat.len_stale = stale_reg;
    assign stat.cfg_write = cfg_we;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_distance = out_dist_reg;
    assign out_last     = out_last_reg;
    assign out_status   = out_stat_reg;

endmodule

FILE: rtl/scan_ring_buffer.sv
// scan_ring_buffer: top level, ring of range scans with read-out and angle query
// depends on srb_pkg, srb_if, srb_ctrl and srb_dp (which holds srb_div)
//
// the block keeps a ring of SCANS scan records in one single-port-write,
// single-port-read store of SCANS x 2^POS_W readings; each record holds up to
// 18000/resolution+1 readings, and that record length is recomputed by the
// shared one-bit-per-cycle divider after every resolution write, during which
// item.ready stays low, the write cycle included. one word is handled at a
// time: a write, clear or read of the oldest scan passes from acceptance to
// the next acceptance through capture, execute with the store access and
// response, and a distance query on a non-empty ring also waits for its
// angle/resolution index to come out of the same 15-step divider before the
// store is read. the result sits in an output register, so a result that is
// not taken holds off only the response step of the next word. scan lengths
// and store contents are not cleared at reset; only committed scans are ever
// read, and readings past a scan's stored length come back as zero
module scan_ring_buffer (
    input  logic                       clk,
    input  logic                       rst_n,
    srb_in_if.sink                     item,
    srb_out_if.source                  result,
    input  logic                       cfg_we,
    input  logic [srb_pkg::RES_W-1:0]  cfg_wdata
);
    import srb_pkg::*;

    srb_cmd_t  cmd;
    srb_stat_t stat;
    logic      in_ready;

    // sequencer: capture, execute, divide, look up, respond, and record-length recompute
    srb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store, ring pointers, divider and output register
    srb_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_func      (item.func),
        .in_reading   (item.reading),
        .in_last      (item.last_reading),
        .in_angle     (item.angle_centideg),
        .out_ready    (result.ready),
        .out_valid    (result.valid),
        .out_distance (result.distance),
        .out_last     (result.last_of_scan),
        .out_status   (result.status)
    );

    assign item.ready = in_ready;

endmodule

FILE: tb/sv/scan_ring_buffer_tb.sv
`timescale 1ns / 100ps
// scan_ring_buffer_tb: self-checking bench for the scan ring buffer
// uses srb_pkg, srb_in_if and srb_out_if from the rtl, plus scan_ring_buffer itself
module scan_ring_buffer_tb;
    import srb_pkg::*;

    // one input word and one result word, at the widths of the channels
    typedef struct packed {
        func_t                   func;
        logic [READING_BITS-1:0] reading;
        logic                    last;
        logic [ANGLE_W-1:0]      angle;
    } scan_word_t;

    typedef struct packed {
        logic [READING_BITS-1:0] distance;
        logic                    last_of_scan;
        status_t                 status;
    } scan_result_t;

    // a directed row: the word, and a hand-written answer where typed is set
    typedef struct packed {
        scan_word_t   word;
        bit           typed;
        scan_result_t answer;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 24;
    localparam int PHASES        = 6;

    // opening rows, all at the reset step of 1 degree (181 readings per record)
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // nothing stored yet: read and query both answer empty
        '{'{FUNC_READ,  16'h0000, 1'b0, 15'd0},     1'b1, '{16'h0000, 1'b0, STATUS_EMPTY}},
        '{'{FUNC_QUERY, 16'h0000, 1'b0, 15'd0},     1'b1, '{16'h0000, 1'b0, STATUS_EMPTY}},
        // a short scan of three readings, extremes of the reading field
        '{'{FUNC_WRITE, 16'hFFFF, 1'b0, 15'd0},     1'b0, '{16'h0000, 1'b0, STATUS_OK}},
        '{'{FUNC_WRITE, 16'h0000, 1'b0, 15'd0},     1'b0, '{16'h0000, 1'b0, STATUS_OK}},
        '{'{FUNC_WRITE, 16'h8001, 1'b1, 15'd0},     1'b0, '{16'h0000, 1'b0, STATUS_OK}},
        // first angle, last angle (past the short scan), out of range, then an angle inside it and a read
        '{'{FUNC_QUERY, 16'h0000, 1'b0, 15'd0},     1'b0, '{16'h0000, 1'b0, STATUS_OK}},
        '{'{FUNC_QUERY, 16'h0000, 1'b0, 15'd18000}, 1'b0, '{16'h0000, 1'b0, STATUS_OK}},
        '{'{FUNC_QUERY, 16'h0000, 1'b0, 15'd18100}, 1'b1, '{16'h0000, 1'b0, STATUS_RANGE}},
        '{'{FUNC_QUERY, 16'h0000, 1'b0, 15'd32767}, 1'b1, '{16'h0000, 1'b0, STATUS_RANGE}},
        '{'{FUNC_QUERY, 16'h0000, 1'b0, 15'd199},   1'b0, '{16'h0000, 1'b0, STATUS_OK}},
        '{'{FUNC_READ,  16'h0000, 1'b0, 15'd0},     1'b0, '{16'h0000, 1'b0, STATUS_OK}},
        // seven one-reading scans fill the ring
        '{'{FUNC_WRITE, 16'h5555, 1'b1, 15'd0},     1'b0, '{16'h0000, 1'b0, STATUS_OK}},
        '{'{FUNC_WRITE, 16'hAAAA, 1'b1, 15'd0},     1'b0, '{16'h0000, 1'b0, STATUS_OK}},
        '{'{FUNC_WRITE, 16'h0F0F, 1'b1, 15'd0},     1'b0, '{16'h0000, 1'b0, STATUS_OK}},
        '{'{FUNC_WRITE, 16'hF0F0, 1'b1, 15'd0},     1'b0, '{16'h0000, 1'b0, STATUS_OK}},
        '{'{FUNC_WRITE, 16'h00FF, 1'b1, 15'd0},     1'b0, '{16'h0000, 1'b0, STATUS_OK}},
        '{'{FUNC_WRITE, 16'hFF00, 1'b1, 15'd0},     1'b0, '{16'h0000, 1'b0, STATUS_OK}},
        '{'{FUNC_WRITE, 16'h7FFF, 1'b1, 15'd0},     1'b0, '{16'h0000, 1'b0, STATUS_OK}},
        // ring full: this scan pushes out the half-read oldest one
        '{'{FUNC_WRITE, 16'h1234, 1'b1, 15'd0},     1'b0, '{16'h0000, 1'b0, STATUS_OK}},
        '{'{FUNC_READ,  16'h0000, 1'b0, 15'd0},     1'b0, '{16'h0000, 1'b0, STATUS_OK}},
        '{'{FUNC_QUERY, 16'h0000, 1'b0, 15'd100},   1'b0, '{16'h0000, 1'b0, STATUS_OK}},
        // clear, then the ring is empty again
        '{'{FUNC_CLEAR, 16'h0000, 1'b0, 15'd0},     1'b1, '{16'h0000, 1'b0, STATUS_OK}},
        '{'{FUNC_READ,  16'h0000, 1'b0, 15'd0},     1'b1, '{16'h0000, 1'b0, STATUS_EMPTY}},
        '{'{FUNC_QUERY, 16'h0000, 1'b0, 15'd9000},  1'b1, '{16'h0000, 1'b0, STATUS_EMPTY}}
    };

    // step written before each random phase; the last one is drawn at run time
    localparam int unsigned PHASE_STEP [PHASES]  = '{127, 55, 0, 10, 100, 0};
    localparam int unsigned PHASE_WORDS [PHASES] = '{120, 70, 50, 40, 80, 60};

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [RES_W-1:0]    cfg_wdata;

    srb_in_if  item_ch ();
    srb_out_if result_ch ();

    scan_ring_buffer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ---------------------------------------------------------------
    // shadow copy of the ring, advanced once per accepted word
    // ---------------------------------------------------------------
    int unsigned             step_centideg = RES_RESET;
    bit [READING_BITS-1:0]   ring_store [SCANS][MAX_READINGS];
    int unsigned             slot_len [SCANS] = '{default: 0};
    int unsigned             ring_oldest = 0;
    int unsigned             ring_fill   = 0;
    int unsigned             ring_count  = 0;
    int unsigned             fill_pos    = 0;
    int unsigned             drain_pos   = 0;

    // answers still owed by the block, oldest first
    scan_result_t            answers_due [$];

    int unsigned             tx_idle_pct = 11;
    int unsigned             rx_idle_pct = 80;
    int unsigned             words_sent  = 0;
    int unsigned             bad_answers = 0;

    // tallies for the closing summary
    int unsigned             scans_stored   = 0;
    int unsigned             scans_read_out = 0;
    int unsigned             scans_dropped  = 0;
    int unsigned             empty_answers  = 0;
    int unsigned             range_answers  = 0;

    // out-of-range register values saturate to the legal step range
    function automatic int unsigned clamped_step();
        if (step_centideg < RES_MIN)
            return RES_MIN;
        if (step_centideg > RES_MAX)
            return RES_MAX;
        return step_centideg;
    endfunction

    // readings per record at the current step, capped by the store
    function automatic int unsigned record_len();
        int unsigned n;
        n = HALF_TURN_CENTIDEG / clamped_step() + 1;
        return (n > MAX_READINGS) ? MAX_READINGS : n;
    endfunction

    // a short scan reads back zero past its stored length
    function automatic logic [READING_BITS-1:0] stored_reading(int unsigned slot,
                                                               int unsigned pos);
        return (pos < slot_len[slot]) ? ring_store[slot][pos] : '0;
    endfunction

    function automatic void retire_oldest();
        ring_oldest = (ring_oldest + 1) % SCANS;
        ring_count  = ring_count - 1;
        drain_pos   = 0;
    endfunction

    // answer of the ring to one word, updating the shadow state
    function automatic scan_result_t ring_step(scan_word_t w);
        scan_result_t r;
        int unsigned  len;
        int unsigned  idx;
        int unsigned  newest;
        r   = '{distance: '0, last_of_scan: 1'b0, status: STATUS_OK};
        len = record_len();
        case (w.func)
            FUNC_WRITE:
            begin
                // a new scan into a full ring pushes out the oldest
                if (fill_pos == 0 && ring_count >= SCANS)
                begin
                    retire_oldest();
                    scans_dropped++;
                end
                // readings past the record length are dropped
                if (fill_pos < len)
                begin
                    ring_store[ring_fill][fill_pos] = w.reading;
                    fill_pos++;
                end
                if (w.last)
                begin
                    slot_len[ring_fill] = fill_pos;
                    ring_fill  = (ring_fill + 1) % SCANS;
                    ring_count = ring_count + 1;
                    fill_pos   = 0;
                    scans_stored++;
                end
            end
            FUNC_READ:
            begin
                if (ring_count == 0)
                begin
                    r.status = STATUS_EMPTY;
                    empty_answers++;
                end
                else
                begin
                    r.distance = stored_reading(ring_oldest, drain_pos);
                    // a shrunk record can end the scan early
                    if (drain_pos + 1 >= len)
                    begin
                        r.last_of_scan = 1'b1;
                        retire_oldest();
                        scans_read_out++;
                    end
                    else
                        drain_pos++;
                end
            end
            FUNC_CLEAR:
            begin
                ring_oldest = 0;
                ring_fill   = 0;
                ring_count  = 0;
                fill_pos    = 0;
                drain_pos   = 0;
            end
            default:
            begin
                if (ring_count == 0)
                begin
                    r.status = STATUS_EMPTY;
                    empty_answers++;
                end
                else
                begin
                    idx    = w.angle / clamped_step();
                    newest = (ring_fill + SCANS - 1) % SCANS;
                    if (idx >= len)
                    begin
                        r.status = STATUS_RANGE;
                        range_answers++;
                    end
                    else
                        r.distance = stored_reading(newest, idx);
                end
            end
        endcase
        return r;
    endfunction

    // mostly random readings, with the two extremes showing up often
    function automatic logic [READING_BITS-1:0] random_reading();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            default: return READING_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------

    // present one word after random idle cycles and hold it until taken;
    // valid is left high so back-to-back words need no second assignment
    task automatic send_word(input scan_word_t w, input bit typed,
                             input scan_result_t typed_answer);
        scan_result_t predicted;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.func           <= w.func;
        item_ch.reading        <= w.reading;
        item_ch.last_reading   <= w.last;
        item_ch.angle_centideg <= w.angle;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        // the shadow ring always advances; a typed answer overrides its result
        predicted = ring_step(w);
        answers_due.insert(answers_due.size(), typed ? typed_answer : predicted);
        words_sent++;
    endtask

    // stop sending until every owed answer has come back
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (answers_due.size() != 0);
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    // hard limit on the whole run, far above the slowest legal run
    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // output side: random back-pressure and the answer check
    // ---------------------------------------------------------------
    initial
    begin
        scan_result_t want;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                if (answers_due.size() == 0)
                begin
                    $display("%0t: result word with nothing owed: dist %h last %b status %0d",
                             $time, result_ch.distance, result_ch.last_of_scan,
                             result_ch.status);
                    bad_answers++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (result_ch.distance !== want.distance
                        || result_ch.last_of_scan !== want.last_of_scan
                        || result_ch.status !== want.status)
                    begin
                        $display("%0t: mismatch: expected dist %h last %b status %0d, %s",
                                 $time, want.distance, want.last_of_scan, want.status,
                                 $sformatf("got dist %h last %b status %0d",
                                           result_ch.distance, result_ch.last_of_scan,
                                           result_ch.status));
                        bad_answers++;
                    end
                end
            end
            result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // stimulus: reset, directed rows, then random phases
    // ---------------------------------------------------------------
    initial
    begin
        scan_word_t   w;
        int unsigned  ph;
        int unsigned  i;
        int unsigned  k;
        int unsigned  n;
        int unsigned  pick;
        int unsigned  cur_len;
        int unsigned  stop_at;
        int unsigned  new_step;
        int unsigned  last_step;
        bit           abandon;

        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_wdata              <= '0;
        item_ch.valid          <= 1'b0;
        item_ch.func           <= FUNC_WRITE;
        item_ch.reading        <= '0;
        item_ch.last_reading   <= 1'b0;
        item_ch.angle_centideg <= '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the first idling mix
        for (i = 0; i < DIRECTED_ROWS; i++)
            send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].answer);
        drain_results();

        last_step = 0;
        for (ph = 0; ph < PHASES; ph++)
        begin
            // sender-light/receiver-heavy, then swapped, then no idling at all
            case (ph / 2)
                0:
                begin
                    tx_idle_pct = 11;
                    rx_idle_pct = 80;
                end
                1:
                begin
                    tx_idle_pct = 80;
                    rx_idle_pct = 11;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase

            // new step only while the block is idle; it re-derives the record
            // length afterwards and holds ready low meanwhile
            new_step = (ph == PHASES - 1) ? $urandom_range(11, 99) : PHASE_STEP[ph];
            last_step = new_step;
            cfg_wdata <= RES_W'(new_step);
            cfg_we    <= 1'b1;
            @(posedge clk);
            cfg_we        <= 1'b0;
            step_centideg  = new_step;

            stop_at = words_sent + PHASE_WORDS[ph];
            while (words_sent < stop_at)
            begin
                pick    = $urandom_range(0, 99);
                cur_len = record_len();
                if (pick < 40)
                begin
                    // one scan: mostly short, sometimes long, rarely past
                    // the record length; now and then left unfinished
                    case ($urandom_range(0, 9))
                        0:       n = (cur_len <= 200) ? $urandom_range(cur_len - 2, cur_len + 3)
                                                      : $urandom_range(1, 8);
                        1, 2:    n = $urandom_range(9, 40);
                        default: n = $urandom_range(1, 8);
                    endcase
                    // keep the phase near its word budget
                    if (n > stop_at - words_sent)
                        n = stop_at - words_sent;
                    abandon = ($urandom_range(0, 9) == 0);
                    for (k = 0; k < n; k++)
                    begin
                        w.func    = FUNC_WRITE;
                        w.reading = random_reading();
                        w.last    = (k == n - 1) && !abandon;
                        w.angle   = ANGLE_W'($urandom_range(0, 32767));
                        send_word(w, 1'b0, '0);
                    end
                end
                else if (pick < 70)
                begin
                    // reads of the oldest scan: a few, the rest of the scan,
                    // or at fine steps a long run so a later coarse step
                    // finds the read position past the shorter record
                    if ($urandom_range(0, 5) == 0)
                    begin
                        if (cur_len > 200)
                            n = $urandom_range(150, 260);
                        else if (ring_count != 0 && drain_pos + 1 < cur_len)
                            n = cur_len - drain_pos;
                        else
                            n = 1;
                    end
                    else
                        n = $urandom_range(1, 12);
                    if (n > stop_at - words_sent)
                        n = stop_at - words_sent;
                    for (k = 0; k < n; k++)
                    begin
                        w.func    = FUNC_READ;
                        w.reading = READING_BITS'($urandom_range(0, 65535));
                        w.last    = 1'($urandom_range(0, 1));
                        w.angle   = ANGLE_W'($urandom_range(0, 32767));
                        send_word(w, 1'b0, '0);
                    end
                end
                else if (pick < 90)
                begin
                    // angle queries: in range, at the record edge, or anywhere
                    n = $urandom_range(1, 6);
                    for (k = 0; k < n; k++)
                    begin
                        w.func    = FUNC_QUERY;
                        w.reading = READING_BITS'($urandom_range(0, 65535));
                        w.last    = 1'($urandom_range(0, 1));
                        case ($urandom_range(0, 7))
                            0, 1:    w.angle = ANGLE_W'($urandom_range(0, 32767));
                            2:       w.angle = ANGLE_W'((cur_len - 1 + $urandom_range(0, 1))
                                                        * clamped_step());
                            default: w.angle = ANGLE_W'($urandom_range(0, 18000));
                        endcase
                        send_word(w, 1'b0, '0);
                    end
                end
                else if (pick < 94)
                begin
                    w.func    = FUNC_CLEAR;
                    w.reading = READING_BITS'($urandom_range(0, 65535));
                    w.last    = 1'($urandom_range(0, 1));
                    w.angle   = ANGLE_W'($urandom_range(0, 32767));
                    send_word(w, 1'b0, '0);
                end
                else
                begin
                    // noise: any function with any field values
                    w.func    = func_t'($urandom_range(0, 3));
                    w.reading = random_reading();
                    w.last    = 1'($urandom_range(0, 1));
                    w.angle   = ANGLE_W'($urandom_range(0, 32767));
                    send_word(w, 1'b0, '0);
                end

                // occasional full stop of the sender until the block catches up
                if ($urandom_range(0, 29) == 0)
                    drain_results();
            end
            drain_results();
        end

        // tail: let any stray result word show up
        repeat (40)
            @(posedge clk);

        $display("covered %0d words: %0d scans stored, %0d read out, %0d pushed out of a full ring",
                 words_sent, scans_stored, scans_read_out, scans_dropped);
        $display("steps 100 127 55 0 10 100 %0d; %0d empty-ring and %0d out-of-range answers",
                 last_step, empty_answers, range_answers);
        if (bad_answers == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
